// ----- hdl/hsv2rgb_pkg.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared pixel types, hue sector codes and conversion constants.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

	typedef struct packed {
		logic signed [15:0] hue;
		logic signed [15:0] saturation;
		logic signed [15:0] value_level;
		logic [7:0]         alpha;
	} hsv_pixel_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha_out;
	} rgb_pixel_t;

	// 60-degree hue sectors, named by the two primaries they span
	typedef enum logic [2:0] {
		SEC_RED_YEL = 3'd0,
		SEC_YEL_GRN = 3'd1,
		SEC_GRN_CYN = 3'd2,
		SEC_CYN_BLU = 3'd3,
		SEC_BLU_MAG = 3'd4,
		SEC_MAG_RED = 3'd5
	} sector_t;

	localparam int unsigned HUE_WRAP    = 360;
	localparam int unsigned SECTOR_DEG  = 60;
	// 92 * 360: lifts any 16-bit signed hue into a positive 17-bit value
	localparam int unsigned HUE_BIAS    = 33120;
	localparam int unsigned HUE_BIAS_W  = 17;
	// floor(2^24 / 360): quotient estimate is exact or one low
	localparam int unsigned RECIP_360   = 46603;
	localparam int unsigned RECIP_SHIFT = 24;
	localparam int unsigned PROD_W      = 32;
	localparam int unsigned QUOT_W      = 8;
	localparam int unsigned HUE_RAW_W   = 10;
	localparam int unsigned HUE_W       = 9;
	localparam int unsigned REM_W       = 6;

endpackage

// ----- hdl/hsv2rgb_front.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_front
// Stages 1-3: clamp saturation and value, wrap hue into 0..359, split into
// sector and remainder.
// ----------------------------------------------------------------------------
module hsv2rgb_front import hsv2rgb_pkg::*; #(
	parameter int unsigned FRAC_BITS = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 vld_in,
	input  hsv_pixel_t           pix_in,
	output logic                 vld_s3,
	output sector_t              sector_s3,
	output logic [REM_W-1:0]     rem_s3,
	output logic [FRAC_BITS:0]   sat_s3,
	output logic [FRAC_BITS:0]   val_s3,
	output logic [7:0]           alpha_s3
);

	localparam int unsigned ONE = 1 << FRAC_BITS;

	function automatic logic [FRAC_BITS:0] clamp_level(input logic [15:0] x);
		logic signed [16:0] xe;
		logic signed [16:0] one_e;
		xe    = $signed({x[15], x});
		one_e = $signed(17'(ONE));
		if (x[15]) begin
			clamp_level = '0;
		end else if (xe > one_e) begin
			clamp_level = (FRAC_BITS + 1)'(ONE);
		end else begin
			clamp_level = x[FRAC_BITS:0];
		end
	endfunction

	// stage 1
	logic                    vld_s1;
	logic [HUE_BIAS_W-1:0]   hue_s1;
	logic [PROD_W-1:0]       prod_s1;
	logic [FRAC_BITS:0]      sat_s1, val_s1;
	logic [7:0]              alpha_s1;
	logic [HUE_BIAS_W-1:0]   hue_c;
	logic [PROD_W-1:0]       prod_c;

	// stage 2
	logic                    vld_s2;
	logic [HUE_RAW_W-1:0]    hraw_s2;
	logic [FRAC_BITS:0]      sat_s2, val_s2;
	logic [7:0]              alpha_s2;
	logic [QUOT_W-1:0]       quot_c;
	logic [HUE_BIAS_W-1:0]   diff_c;

	// stage 3 inputs
	logic [HUE_W-1:0]        hw_c;
	logic [HUE_W-1:0]        base_c;
	sector_t                 sector_c;
	logic [HUE_W-1:0]        rem_c;

	assign hue_c  = HUE_BIAS_W'({pix_in.hue[15], pix_in.hue}) + HUE_BIAS_W'(HUE_BIAS);
	assign prod_c = PROD_W'(hue_c) * PROD_W'(RECIP_360);

	assign quot_c = prod_s1[RECIP_SHIFT +: QUOT_W];
	assign diff_c = hue_s1 - HUE_BIAS_W'(HUE_BIAS_W'(quot_c) * HUE_BIAS_W'(HUE_WRAP));

	// one correction step: the quotient estimate may be one low
	assign hw_c = (hraw_s2 >= HUE_RAW_W'(HUE_WRAP)) ?
		HUE_W'(hraw_s2 - HUE_RAW_W'(HUE_WRAP)) : HUE_W'(hraw_s2);

	always_comb begin
		priority if (hw_c < HUE_W'(SECTOR_DEG)) begin
			sector_c = SEC_RED_YEL;
			base_c   = '0;
		end else if (hw_c < HUE_W'(2 * SECTOR_DEG)) begin
			sector_c = SEC_YEL_GRN;
			base_c   = HUE_W'(SECTOR_DEG);
		end else if (hw_c < HUE_W'(3 * SECTOR_DEG)) begin
			sector_c = SEC_GRN_CYN;
			base_c   = HUE_W'(2 * SECTOR_DEG);
		end else if (hw_c < HUE_W'(4 * SECTOR_DEG)) begin
			sector_c = SEC_CYN_BLU;
			base_c   = HUE_W'(3 * SECTOR_DEG);
		end else if (hw_c < HUE_W'(5 * SECTOR_DEG)) begin
			sector_c = SEC_BLU_MAG;
			base_c   = HUE_W'(4 * SECTOR_DEG);
		end else begin
			sector_c = SEC_MAG_RED;
			base_c   = HUE_W'(5 * SECTOR_DEG);
		end
	end

	assign rem_c = hw_c - base_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hue_s1    <= hue_c;
			prod_s1   <= prod_c;
			sat_s1    <= clamp_level(pix_in.saturation);
			val_s1    <= clamp_level(pix_in.value_level);
			alpha_s1  <= pix_in.alpha;

			hraw_s2   <= HUE_RAW_W'(diff_c);
			sat_s2    <= sat_s1;
			val_s2    <= val_s1;
			alpha_s2  <= alpha_s1;

			sector_s3 <= sector_c;
			rem_s3    <= REM_W'(rem_c);
			sat_s3    <= sat_s2;
			val_s3    <= val_s2;
			alpha_s3  <= alpha_s2;
		end
	end

endmodule

// ----- hdl/hsv2rgb_level.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_level
// Stages 4-5: form 1-S, 60-S*f and 60-S*(1-f) terms, then multiply by V.
// ----------------------------------------------------------------------------
module hsv2rgb_level import hsv2rgb_pkg::*; #(
	parameter int unsigned FRAC_BITS = 12
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        vld_s3,
	input  sector_t                     sector_s3,
	input  logic [REM_W-1:0]            rem_s3,
	input  logic [FRAC_BITS:0]          sat_s3,
	input  logic [FRAC_BITS:0]          val_s3,
	input  logic [7:0]                  alpha_s3,
	output logic                        vld_s5,
	output sector_t                     sector_s5,
	output logic [FRAC_BITS:0]          val_s5,
	output logic [7:0]                  alpha_s5,
	output logic [2*FRAC_BITS+1:0]      mp_s5,
	output logic [2*FRAC_BITS+6:0]      mq_s5,
	output logic [2*FRAC_BITS+6:0]      mt_s5
);

	localparam int unsigned LW  = FRAC_BITS + 1;
	localparam int unsigned XW  = FRAC_BITS + 6;
	localparam int unsigned MPW = 2 * LW;
	localparam int unsigned MQW = LW + XW;
	localparam int unsigned ONE = 1 << FRAC_BITS;
	localparam logic [XW-1:0] SIXTY_ONE = XW'(SECTOR_DEG * ONE);

	logic                 vld_s4;
	sector_t              sector_s4;
	logic [LW-1:0]        val_s4;
	logic [7:0]           alpha_s4;
	logic [LW-1:0]        comp_s4;
	logic [XW-1:0]        xq_s4, xt_s4;
	logic [XW-1:0]        sr_q_c, sr_t_c;

	assign sr_q_c = XW'(sat_s3) * XW'(rem_s3);
	assign sr_t_c = XW'(sat_s3) * (XW'(SECTOR_DEG) - XW'(rem_s3));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sector_s4 <= sector_s3;
			val_s4    <= val_s3;
			alpha_s4  <= alpha_s3;
			comp_s4   <= LW'(ONE) - sat_s3;
			xq_s4     <= SIXTY_ONE - sr_q_c;
			xt_s4     <= SIXTY_ONE - sr_t_c;

			sector_s5 <= sector_s4;
			val_s5    <= val_s4;
			alpha_s5  <= alpha_s4;
			mp_s5     <= MPW'(val_s4) * MPW'(comp_s4);
			mq_s5     <= MQW'(val_s4) * MQW'(xq_s4);
			mt_s5     <= MQW'(val_s4) * MQW'(xt_s4);
		end
	end

endmodule

// ----- hdl/hsv2rgb_scale.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_scale
// Stage 6: scale levels to bytes by constant shift-add, map sector to RGB.
// ----------------------------------------------------------------------------
module hsv2rgb_scale import hsv2rgb_pkg::*; #(
	parameter int unsigned FRAC_BITS = 12
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        vld_s5,
	input  sector_t                     sector_s5,
	input  logic [FRAC_BITS:0]          val_s5,
	input  logic [7:0]                  alpha_s5,
	input  logic [2*FRAC_BITS+1:0]      mp_s5,
	input  logic [2*FRAC_BITS+6:0]      mq_s5,
	input  logic [2*FRAC_BITS+6:0]      mt_s5,
	output logic                        vld_s6,
	output rgb_pixel_t                  pix_s6
);

	localparam int unsigned LW   = FRAC_BITS + 1;
	localparam int unsigned VSW  = LW + 8;
	localparam int unsigned PSW  = 2 * FRAC_BITS + 10;
	localparam int unsigned QSW  = 2 * FRAC_BITS + 12;

	// 255/60 = 17/4, so q and t levels scale by 17 and drop 2F+2 bits
	logic [VSW-1:0] v255_c;
	logic [PSW-1:0] p255_c;
	logic [QSW-1:0] q17_c, t17_c;
	logic [7:0]     bv_c, bp_c, bq_c, bt_c;
	rgb_pixel_t     pix_c;

	assign v255_c = VSW'({val_s5, 8'b0}) - VSW'(val_s5);
	assign p255_c = PSW'({mp_s5, 8'b0}) - PSW'(mp_s5);
	assign q17_c  = QSW'({mq_s5, 4'b0}) + QSW'(mq_s5);
	assign t17_c  = QSW'({mt_s5, 4'b0}) + QSW'(mt_s5);

	assign bv_c = v255_c[FRAC_BITS +: 8];
	assign bp_c = p255_c[2*FRAC_BITS +: 8];
	assign bq_c = q17_c[2*FRAC_BITS+2 +: 8];
	assign bt_c = t17_c[2*FRAC_BITS+2 +: 8];

	always_comb begin
		pix_c.alpha_out = alpha_s5;
		unique case (sector_s5)
			SEC_YEL_GRN: begin
				pix_c.red = bq_c; pix_c.green = bv_c; pix_c.blue = bp_c;
			end
			SEC_GRN_CYN: begin
				pix_c.red = bp_c; pix_c.green = bv_c; pix_c.blue = bt_c;
			end
			SEC_CYN_BLU: begin
				pix_c.red = bp_c; pix_c.green = bq_c; pix_c.blue = bv_c;
			end
			SEC_BLU_MAG: begin
				pix_c.red = bt_c; pix_c.green = bp_c; pix_c.blue = bv_c;
			end
			SEC_MAG_RED: begin
				pix_c.red = bv_c; pix_c.green = bp_c; pix_c.blue = bq_c;
			end
			default: begin
				pix_c.red = bv_c; pix_c.green = bt_c; pix_c.blue = bp_c;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pix_s6 <= pix_c;
		end
	end

endmodule

// ----- hdl/hsv_to_rgb_pixel_core.sv -----
// Each accepted pixel passes stages s1 through s6; s6 is the output register.
// Throughput: one pixel per cycle; the six stages advance together whenever
// the output register is empty or its pixel is being taken.
// Reset: arst_n clears all stage valid bits at once; data registers keep
// whatever they hold and are ignored until a valid pixel reaches them.
// ----------------------------------------------------------------------------
// hsv_to_rgb_pixel_core
// HSV to RGB converter: hue wrapped modulo 360, saturation and value clamped
// to 0..1.0 in fixed point, each channel floor(255 * level), alpha copied.
// ----------------------------------------------------------------------------
module hsv_to_rgb_pixel_core import hsv2rgb_pkg::*; #(
	parameter int unsigned FRAC_BITS = 12
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  hsv_pixel_t in_pixel,
	output logic       out_valid,
	input  logic       out_ready,
	output rgb_pixel_t out_pixel
);

	// Stage plan:
	//   s1  clamp S and V, bias hue positive, multiply by reciprocal of 360
	//   s2  hue minus quotient * 360 (raw remainder, 0..719)
	//   s3  correct remainder, split into sector and offset within sector
	//   s4  1-S and the two 60-S*k terms
	//   s5  multiply the three terms by V
	//   s6  constant scale to bytes, sector mux, output register

	// Advance the whole pipe when the output slot is free or being drained;
	// hold every stage otherwise, so a stall drops and repeats nothing.
	logic                     en;

	logic                     vld_s3;
	sector_t                  sector_s3;
	logic [REM_W-1:0]         rem_s3;
	logic [FRAC_BITS:0]       sat_s3, val_s3;
	logic [7:0]               alpha_s3;

	logic                     vld_s5;
	sector_t                  sector_s5;
	logic [FRAC_BITS:0]       val_s5;
	logic [7:0]               alpha_s5;
	logic [2*FRAC_BITS+1:0]   mp_s5;
	logic [2*FRAC_BITS+6:0]   mq_s5, mt_s5;

	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	hsv2rgb_front #(
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.vld_in    (in_valid),
		.pix_in    (in_pixel),
		.vld_s3    (vld_s3),
		.sector_s3 (sector_s3),
		.rem_s3    (rem_s3),
		.sat_s3    (sat_s3),
		.val_s3    (val_s3),
		.alpha_s3  (alpha_s3)
	);

	hsv2rgb_level #(
		.FRAC_BITS (FRAC_BITS)
	) u_level (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.vld_s3    (vld_s3),
		.sector_s3 (sector_s3),
		.rem_s3    (rem_s3),
		.sat_s3    (sat_s3),
		.val_s3    (val_s3),
		.alpha_s3  (alpha_s3),
		.vld_s5    (vld_s5),
		.sector_s5 (sector_s5),
		.val_s5    (val_s5),
		.alpha_s5  (alpha_s5),
		.mp_s5     (mp_s5),
		.mq_s5     (mq_s5),
		.mt_s5     (mt_s5)
	);

	// Final stage doubles as the output register.
	hsv2rgb_scale #(
		.FRAC_BITS (FRAC_BITS)
	) u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.vld_s5    (vld_s5),
		.sector_s5 (sector_s5),
		.val_s5    (val_s5),
		.alpha_s5  (alpha_s5),
		.mp_s5     (mp_s5),
		.mq_s5     (mq_s5),
		.mt_s5     (mt_s5),
		.vld_s6    (out_valid),
		.pix_s6    (out_pixel)
	);

endmodule

// ----- hdl/hsv2rgb_checker.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_checker
// Port-level checks on the converter, bound to the top level.
// ----------------------------------------------------------------------------
module hsv2rgb_checker import hsv2rgb_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input hsv_pixel_t in_pixel,
	input logic       out_valid,
	input logic       out_ready,
	input rgb_pixel_t out_pixel
);

	logic acc;
	assign acc = in_valid && in_ready;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_pixel))
		else $error("output pixel changed while stalled");

	// input backpressure only comes from a blocked output
	a_ready_src: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output stall");

	// through an unstalled pipe, alpha carried along to the output
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		acc ##1 in_ready ##1 in_ready ##1 in_ready ##1 in_ready ##1 in_ready
		|=> out_valid && out_pixel.alpha_out == $past(in_pixel.alpha, 6))
		else $error("transfer did not appear after six cycles");

	// zero or negative value gives black
	a_dark: assert property (@(posedge clk) disable iff (!arst_n)
		acc ##1 in_ready ##1 in_ready ##1 in_ready ##1 in_ready ##1 in_ready
		|=> ($past(in_pixel.value_level[15], 6) || $past(in_pixel.value_level, 6) == 16'd0)
			-> (out_pixel.red == 8'd0 && out_pixel.green == 8'd0 && out_pixel.blue == 8'd0))
		else $error("dark pixel produced color");

	// zero or negative saturation gives gray
	a_gray: assert property (@(posedge clk) disable iff (!arst_n)
		acc ##1 in_ready ##1 in_ready ##1 in_ready ##1 in_ready ##1 in_ready
		|=> ($past(in_pixel.saturation[15], 6) || $past(in_pixel.saturation, 6) == 16'd0)
			-> (out_pixel.red == out_pixel.green && out_pixel.green == out_pixel.blue))
		else $error("unsaturated pixel not gray");

endmodule

bind hsv_to_rgb_pixel_core hsv2rgb_checker u_hsv2rgb_checker (.*);

// ----- bench/hsv_to_rgb_pixel_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_pixel_core_tb
// Streams HSV pixels through the converter and checks each RGB pixel against
// an in-bench fixed-point predictor, under several input and output idling
// mixes.
// ----------------------------------------------------------------------------
module hsv_to_rgb_pixel_core_tb;
	import hsv2rgb_pkg::*;

	localparam int unsigned        FRAC_BITS   = 12;
	localparam longint unsigned    ONE_LEVEL   = 64'd1 << FRAC_BITS;
	localparam longint unsigned    CHANNEL_MAX = 255;
	localparam int                 FULL_TURN   = int'(HUE_WRAP);
	localparam int                 SECTOR_SPAN = int'(SECTOR_DEG);
	localparam int                 DRAIN_CYCLES = 20;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	hsv_pixel_t in_pixel = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	rgb_pixel_t out_pixel;

	rgb_pixel_t expected_rgb_q[$];
	int         mismatch_count = 0;
	int         send_gap_pct = 0;
	int         out_stall_pct = 0;

	hsv_to_rgb_pixel_core #(
		.FRAC_BITS(FRAC_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_pixel(in_pixel),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_pixel(out_pixel)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor: exact rational levels over the common denominator
	// 60 * one * one, then floor(255 * level) per channel.
	// ------------------------------------------------------------------
	function automatic longint unsigned clamp_level(input logic signed [15:0] raw);
		int x;
		x = raw;
		if (x < 0)
			return 0;
		if (longint'(x) > longint'(ONE_LEVEL))
			return ONE_LEVEL;
		return longint'(x);
	endfunction

	function automatic logic [7:0] level_to_byte(input longint unsigned num,
			input longint unsigned den);
		longint unsigned scaled;
		scaled = (num * CHANNEL_MAX) / den;
		if (scaled > CHANNEL_MAX)
			scaled = CHANNEL_MAX;
		return scaled[7:0];
	endfunction

	function automatic rgb_pixel_t predict_rgb(input hsv_pixel_t px);
		int              hue_deg;
		longint unsigned sat, val, rem, den, lvl_v, lvl_p, lvl_q, lvl_t;
		longint unsigned r_num, g_num, b_num;
		sector_t         sector;
		rgb_pixel_t      res;
		sat = clamp_level(px.saturation);
		val = clamp_level(px.value_level);
		// wrap any signed hue into 0..359
		hue_deg = int'(px.hue) % FULL_TURN;
		if (hue_deg < 0)
			hue_deg += FULL_TURN;
		sector = sector_t'(hue_deg / SECTOR_SPAN);
		rem = longint'(hue_deg % SECTOR_SPAN);
		den = longint'(SECTOR_SPAN) * ONE_LEVEL * ONE_LEVEL;
		lvl_v = val * longint'(SECTOR_SPAN) * ONE_LEVEL;
		lvl_p = val * (ONE_LEVEL - sat) * longint'(SECTOR_SPAN);
		lvl_q = val * (longint'(SECTOR_SPAN) * ONE_LEVEL - sat * rem);
		lvl_t = val * (longint'(SECTOR_SPAN) * ONE_LEVEL
			- sat * (longint'(SECTOR_SPAN) - rem));
		case (sector)
			SEC_YEL_GRN: begin r_num = lvl_q; g_num = lvl_v; b_num = lvl_p; end
			SEC_GRN_CYN: begin r_num = lvl_p; g_num = lvl_v; b_num = lvl_t; end
			SEC_CYN_BLU: begin r_num = lvl_p; g_num = lvl_q; b_num = lvl_v; end
			SEC_BLU_MAG: begin r_num = lvl_t; g_num = lvl_p; b_num = lvl_v; end
			SEC_MAG_RED: begin r_num = lvl_v; g_num = lvl_p; b_num = lvl_q; end
			default: begin r_num = lvl_v; g_num = lvl_t; b_num = lvl_p; end
		endcase
		res.red       = level_to_byte(r_num, den);
		res.green     = level_to_byte(g_num, den);
		res.blue      = level_to_byte(b_num, den);
		res.alpha_out = px.alpha;
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Input side: call right after a rising edge (or at start); drive at the
	// falling edge, hold until the transfer, then record the prediction.
	// ------------------------------------------------------------------
	task automatic send_pixel(input logic signed [15:0] hue,
			input logic signed [15:0] sat, input logic signed [15:0] val,
			input logic [7:0] alpha);
		hsv_pixel_t px;
		px.hue         = hue;
		px.saturation  = sat;
		px.value_level = val;
		px.alpha       = alpha;
		@(negedge clk);
		// insert random gaps before presenting the pixel
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_pixel <= px;
		do @(posedge clk); while (!in_ready);
		expected_rgb_q.push_back(predict_rgb(px));
	endtask

	task automatic report_mismatch(input string what);
		$display("%0t ns: mismatch: %s", $time, what);
		mismatch_count++;
	endtask

	// Output side: stall at random, drive ready at the falling edge
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= out_stall_pct);
	end

	// Check each output transfer against the oldest prediction
	always @(posedge clk) begin
		rgb_pixel_t exp_px;
		if (arst_n && out_valid && out_ready) begin
			if (expected_rgb_q.size() == 0) begin
				report_mismatch($sformatf("unexpected pixel %h", out_pixel));
			end else begin
				exp_px = expected_rgb_q.pop_front();
				if (out_pixel.red !== exp_px.red)
					report_mismatch($sformatf("red got %0d want %0d",
						out_pixel.red, exp_px.red));
				if (out_pixel.green !== exp_px.green)
					report_mismatch($sformatf("green got %0d want %0d",
						out_pixel.green, exp_px.green));
				if (out_pixel.blue !== exp_px.blue)
					report_mismatch($sformatf("blue got %0d want %0d",
						out_pixel.blue, exp_px.blue));
				if (out_pixel.alpha_out !== exp_px.alpha_out)
					report_mismatch($sformatf("alpha_out got %0d want %0d",
						out_pixel.alpha_out, exp_px.alpha_out));
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Both sides of every 60-degree sector boundary, full and half saturation
	task automatic test_sector_edges();
		int hues[12] = '{0, 59, 60, 119, 120, 179, 180, 239, 240, 299, 300, 359};
		foreach (hues[i])
			send_pixel(16'(hues[i]), (i % 2 == 0) ? 16'(ONE_LEVEL) : 16'(ONE_LEVEL / 2),
				16'(ONE_LEVEL), 8'(8'hA5 + i));
	endtask

	// Negative and large hues wrap into 0..359
	task automatic test_hue_wrap();
		send_pixel(-16'sd32768, 16'(ONE_LEVEL), 16'(ONE_LEVEL), 8'd0);
		send_pixel(16'sd32767, 16'(ONE_LEVEL), 16'(ONE_LEVEL), 8'd255);
		send_pixel(-16'sd1, 16'(ONE_LEVEL), 16'(ONE_LEVEL), 8'd1);
		send_pixel(-16'sd360, 16'(ONE_LEVEL), 16'(ONE_LEVEL), 8'd128);
		send_pixel(16'sd360, 16'(ONE_LEVEL), 16'(ONE_LEVEL), 8'd127);
		send_pixel(-16'sd359, 16'(ONE_LEVEL), 16'(ONE_LEVEL), 8'd254);
	endtask

	// Saturation and value clamped at zero and at one
	task automatic test_level_clamp();
		send_pixel(16'sd200, -16'sd32768, 16'sd32767, 8'd255);
		send_pixel(16'sd200, 16'sd32767, -16'sd32768, 8'd0);
		send_pixel(16'sd200, -16'sd1, 16'(ONE_LEVEL), 8'd17);
		send_pixel(16'sd200, 16'(ONE_LEVEL + 1), 16'(ONE_LEVEL - 1), 8'd34);
		send_pixel(16'sd200, 16'sd0, 16'sd0, 8'd51);
		send_pixel(16'sd200, 16'(ONE_LEVEL - 1), 16'(ONE_LEVEL + 1), 8'd68);
	endtask

	function automatic logic signed [15:0] rand_hue();
		case ($urandom_range(4))
			0, 1: return 16'($urandom);
			2: return 16'(int'($urandom_range(3 * FULL_TURN - 1)) - FULL_TURN);
			default: return 16'($urandom_range(FULL_TURN - 1));
		endcase
	endfunction

	// Mostly in-range levels, with edges and out-of-range noise mixed in
	function automatic logic signed [15:0] rand_level();
		case ($urandom_range(9))
			0, 1: return 16'($urandom);
			2: begin
				case ($urandom_range(3))
					0: return 16'sd0;
					1: return 16'(ONE_LEVEL);
					2: return 16'(ONE_LEVEL - 1);
					default: return 16'(ONE_LEVEL + 1);
				endcase
			end
			default: return 16'($urandom_range(int'(ONE_LEVEL)));
		endcase
	endfunction

	task automatic test_random_pixels(input int gap_pct, input int stall_pct,
			input int count);
		send_gap_pct  = gap_pct;
		out_stall_pct = stall_pct;
		repeat (count)
			send_pixel(rand_hue(), rand_level(), rand_level(), 8'($urandom));
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_sector_edges();
		test_hue_wrap();
		test_level_clamp();
		test_random_pixels(0, 0, 450);
		test_random_pixels(86, 0, 450);
		test_random_pixels(0, 86, 450);
		test_random_pixels(26, 26, 450);

		// drop valid once the last transfer is done, then drain the pipe
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_rgb_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("hsv_to_rgb_pixel_core_tb: PASS");
		else
			$display("hsv_to_rgb_pixel_core_tb: FAIL");
		$finish;
	end

	// Guard against a hung handshake
	initial begin
		#5000000;
		$display("hsv_to_rgb_pixel_core_tb: FAIL");
		$finish;
	end

endmodule
